FILE: rtl/core/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants of the channel pattern check responder.
// ----------------------------------------------------------------------------
package cpr_pkg;

  // Request framing and reply bytes
  localparam logic [7:0] START_BYTE = 8'h57;
  localparam logic [7:0] REPLY_HEAD = 8'h7A;

  // Field widths fixed by the interface
  localparam int MAP_BITS    = 12;
  localparam int THRESH_BITS = 12;
  localparam int IDX_BITS    = 4;
  localparam int LVL_BITS_IN = 12;

  // Reply queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Input item kind
  localparam logic KIND_SERIAL = 1'b0;
  localparam logic KIND_LEVEL  = 1'b1;

  // Position inside the three-byte request
  typedef enum logic [1:0] {
    POS_IDLE = 2'd0,
    POS_HIGH = 2'd1,
    POS_LOW  = 2'd2
  } frame_pos_t;

  // Reply byte being emitted
  typedef enum logic [1:0] {
    BYTE_HEAD = 2'd0,
    BYTE_HIGH = 2'd1,
    BYTE_LOW  = 2'd2
  } reply_sel_t;

  // One reply descriptor
  typedef struct packed {
    logic                pattern_match;
    logic                any_active;
    logic [MAP_BITS-1:0] map;
  } reply_t;

  // Push request from front to queue
  typedef struct packed {
    logic   valid;
    reply_t data;
  } reply_push_t;

endpackage

FILE: rtl/core/channel_pattern_check_responder_unit.sv
// ----------------------------------------------------------------------------
// channel_pattern_check_responder_unit
// Serial pattern request responder over a set of thresholded channel levels.
// ----------------------------------------------------------------------------
// Input channel (in_*): one transaction per serial byte or level update.
//   in_tuser = 0 carries a serial byte, in_tuser = 1 a channel level update.
//   A request is 0x57, pattern high byte, pattern low byte.
// Output channel (out_*): three transactions per request: 0x7A, map bits
//   11..8, map bits 7..0; out_tlast marks the third, out_tuser carries the
//   match and any-active flags on all three.
// Configuration: cfg_wr_en writes the level threshold; write it only while
//   no reply is pending.
// Throughput: one input transaction per cycle while the queue is not full
//   and one reply byte per cycle while out_tready is high.
// The descriptor enters the queue when the third request byte is accepted
//   and loads the output register once that register is free. Map and flags
//   are built by one comparator per channel in the accepting cycle.
// A four-entry reply queue separates the input side from the output stage;
//   in_tready drops only while that queue is full, e.g. under a long stall
//   of out_tready. A stalled reply byte is held in the output register.
// Reset (rst_n low, synchronous) clears levels, threshold, framing, queue
//   and output stage.
// ----------------------------------------------------------------------------
module channel_pattern_check_responder_unit #(
  parameter int CHANNEL_COUNT = 12,
  parameter int LEVEL_BITS    = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // rx_byte[7:0], channel_index[11:8],
                                   // channel_level[23:12]
  input  logic        in_tuser,    // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // tx_byte[7:0]
  output logic        out_tlast,
  output logic [1:0]  out_tuser,   // pattern_match[0], any_active[1]
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data  // level_threshold
);

  cpr_pkg::reply_push_t push;
  cpr_pkg::reply_t      head;
  logic                 q_empty;
  logic                 q_full;
  logic                 q_pop;

  cpr_front #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .LEVEL_BITS    (LEVEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .queue_full  (q_full),
    .push        (push)
  );

  cpr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .head  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  cpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/core/cpr_front.sv
// ----------------------------------------------------------------------------
// cpr_front
// Accepts input transactions, keeps channel levels and request framing, and
// builds a reply descriptor when a request completes.
// ----------------------------------------------------------------------------
module cpr_front #(
  parameter int CHANNEL_COUNT = 12,
  parameter int LEVEL_BITS    = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,
  input  logic                             in_tuser,
  input  logic                             cfg_wr_en,
  input  logic [cpr_pkg::THRESH_BITS-1:0]  cfg_wr_data,
  input  logic                             queue_full,
  output cpr_pkg::reply_push_t             push
);

  localparam int CMP_W = (LEVEL_BITS > cpr_pkg::THRESH_BITS) ? LEVEL_BITS
                                                              : cpr_pkg::THRESH_BITS;

  logic [cpr_pkg::THRESH_BITS-1:0] thresh_r;
  logic [LEVEL_BITS-1:0]           level_r [CHANNEL_COUNT];
  cpr_pkg::frame_pos_t             pos_r, pos_nxt;
  logic [3:0]                      pat_high_r, pat_high_nxt;

  logic                             accept;
  logic                             is_serial;
  logic [7:0]                       rx_byte;
  logic [cpr_pkg::IDX_BITS-1:0]     chan_idx;
  logic [cpr_pkg::LVL_BITS_IN-1:0]  chan_level;
  logic [CMP_W-1:0]                 level_ext;
  logic [LEVEL_BITS-1:0]            level_in;
  logic [CHANNEL_COUNT-1:0]         full_map;
  logic [cpr_pkg::MAP_BITS-1:0]     map12;
  logic [cpr_pkg::MAP_BITS-1:0]     pattern;
  logic                             req_done;

  // Unpack the transaction
  assign rx_byte    = in_tdata[7:0];
  assign chan_idx   = in_tdata[11:8];
  assign chan_level = in_tdata[23:12];
  assign level_ext  = CMP_W'(chan_level);
  assign level_in   = level_ext[LEVEL_BITS-1:0];

  assign in_tready = !queue_full;
  assign accept    = in_tvalid && in_tready;
  assign is_serial = (in_tuser == cpr_pkg::KIND_SERIAL);

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // Channel level store and per-channel comparators
  for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_chan
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        level_r[i] <= '0;
      end else if (accept && in_tuser == cpr_pkg::KIND_LEVEL &&
                   chan_idx == cpr_pkg::IDX_BITS'(i)) begin
        level_r[i] <= level_in;
      end
    end
    assign full_map[i] = CMP_W'(level_r[i]) > CMP_W'(thresh_r);
  end

  // Mask the map down to the reply width
  for (genvar i = 0; i < cpr_pkg::MAP_BITS; i++) begin : g_map
    if (i < CHANNEL_COUNT) begin : g_hit
      assign map12[i] = full_map[i];
    end else begin : g_none
      assign map12[i] = 1'b0;
    end
  end

  assign pattern = {pat_high_r, rx_byte};

  // Request framing
  always_comb begin
    pos_nxt      = pos_r;
    pat_high_nxt = pat_high_r;
    req_done     = 1'b0;
    if (accept && is_serial) begin
      unique case (pos_r)
        cpr_pkg::POS_IDLE: begin
          if (rx_byte == cpr_pkg::START_BYTE) begin
            pos_nxt = cpr_pkg::POS_HIGH;
          end
        end
        cpr_pkg::POS_HIGH: begin
          pat_high_nxt = rx_byte[3:0];
          pos_nxt      = cpr_pkg::POS_LOW;
        end
        cpr_pkg::POS_LOW: begin
          req_done = 1'b1;
          pos_nxt  = cpr_pkg::POS_IDLE;
        end
        default: begin
          pos_nxt = cpr_pkg::POS_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= cpr_pkg::POS_IDLE;
      pat_high_r <= '0;
    end else begin
      pos_r      <= pos_nxt;
      pat_high_r <= pat_high_nxt;
    end
  end

  // Hand the finished request to the queue
  assign push.valid              = req_done;
  assign push.data.map           = map12;
  assign push.data.any_active    = |full_map;
  assign push.data.pattern_match = (pattern == map12);

endmodule

FILE: rtl/core/cpr_queue.sv
// ----------------------------------------------------------------------------
// cpr_queue
// Short FIFO of reply descriptors between the front and the back.
// ----------------------------------------------------------------------------
module cpr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpr_pkg::reply_push_t push,
  input  logic                 pop,
  output cpr_pkg::reply_t      head,
  output logic                 empty,
  output logic                 full
);

  cpr_pkg::reply_t                 slot_r [cpr_pkg::QUEUE_DEPTH];
  logic [cpr_pkg::QPTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [cpr_pkg::QCNT_BITS-1:0]   count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == cpr_pkg::QCNT_BITS'(cpr_pkg::QUEUE_DEPTH));
  assign head  = slot_r[rd_ptr_r];

  // Store the descriptor
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot_r[wr_ptr_r] <= push.data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push.valid && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push.valid) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !full) else $error("reply queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("reply queue read while empty");
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!push.valid && !pop) |=> $stable(count_r))
    else $error("reply queue occupancy changed without traffic");
`endif

endmodule

FILE: rtl/core/cpr_back.sv
// ----------------------------------------------------------------------------
// cpr_back
// Takes reply descriptors from the queue and sends the three reply bytes
// through a registered output stage.
// ----------------------------------------------------------------------------
module cpr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  cpr_pkg::reply_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast,
  output logic [1:0]      out_tuser
);

  cpr_pkg::reply_sel_t sel_r, sel_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [7:0]          out_tdata_r, out_tdata_nxt;
  logic                out_tlast_r, out_tlast_nxt;
  logic [1:0]          out_tuser_r, out_tuser_nxt;
  logic                take;

  // Load the output stage when it is empty or being drained
  assign take = (!out_tvalid_r || out_tready) && !empty;

  always_comb begin
    sel_nxt        = sel_r;
    pop            = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    out_tuser_nxt  = out_tuser_r;
    if (take) begin
      out_tvalid_nxt = 1'b1;
      out_tuser_nxt  = {head.any_active, head.pattern_match};
      unique case (sel_r)
        cpr_pkg::BYTE_HEAD: begin
          out_tdata_nxt = cpr_pkg::REPLY_HEAD;
          out_tlast_nxt = 1'b0;
          sel_nxt       = cpr_pkg::BYTE_HIGH;
        end
        cpr_pkg::BYTE_HIGH: begin
          out_tdata_nxt = 8'(head.map[cpr_pkg::MAP_BITS-1:8]);
          out_tlast_nxt = 1'b0;
          sel_nxt       = cpr_pkg::BYTE_LOW;
        end
        cpr_pkg::BYTE_LOW: begin
          out_tdata_nxt = head.map[7:0];
          out_tlast_nxt = 1'b1;
          pop           = 1'b1;
          sel_nxt       = cpr_pkg::BYTE_HEAD;
        end
        default: begin
          sel_nxt = cpr_pkg::BYTE_HEAD;
        end
      endcase
    end
  end

  // Byte select and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r        <= cpr_pkg::BYTE_HEAD;
      out_tvalid_r <= 1'b0;
    end else begin
      sel_r        <= sel_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_last_ends_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tlast_r) |-> (sel_r == cpr_pkg::BYTE_HEAD))
    else $error("last reply byte shown while a reply is still open");
  a_open_reply_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (sel_r != cpr_pkg::BYTE_HEAD) |-> out_tvalid_r)
    else $error("reply open but output stage empty");
`endif

endmodule

FILE: dv/cpr_reply_checker.sv
// ----------------------------------------------------------------------------
// cpr_reply_checker
// Scoreboard for the channel pattern check responder: it follows every
// accepted input and configuration transaction, predicts the reply bytes
// and compares each accepted output transaction against the oldest one due.
// ----------------------------------------------------------------------------
module cpr_reply_checker #(
  parameter int CHANNEL_COUNT = 12,
  parameter int LEVEL_BITS    = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  output int unsigned mismatch_count,
  output int unsigned replies_due
);

  typedef struct {
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       pattern_match;
    logic       any_active;
  } reply_byte_t;

  // Shadow state of the block
  logic [cpr_pkg::THRESH_BITS-1:0] threshold;
  cpr_pkg::frame_pos_t             frame_pos;
  logic [7:0]                      pattern_hi;
  logic [7:0]                      pattern_lo;
  logic [LEVEL_BITS-1:0]           levels [CHANNEL_COUNT];
  reply_byte_t                     expected_replies [$];
  int unsigned                     errors;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 40) begin
      $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    end
    errors++;
  endtask

  // Build the active-channel map and queue the three reply bytes
  task automatic predict_reply();
    logic [15:0]                  full_map;
    logic [cpr_pkg::MAP_BITS-1:0] map;
    logic [15:0]                  requested;
    logic                         match;
    logic                         any;
    full_map = '0;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (levels[i] > threshold) full_map[i] = 1'b1;
    end
    any       = |full_map;
    map       = full_map[cpr_pkg::MAP_BITS-1:0];
    requested = {pattern_hi, pattern_lo};
    match     = (requested[cpr_pkg::MAP_BITS-1:0] == map);
    expected_replies.push_back('{cpr_pkg::REPLY_HEAD, 1'b0, match, any});
    expected_replies.push_back('{{4'h0, map[11:8]}, 1'b0, match, any});
    expected_replies.push_back('{map[7:0], 1'b1, match, any});
  endtask

  // Advance framing or store a level for one input transaction
  task automatic absorb_input(input logic kind, input logic [23:0] data);
    logic [7:0]  rx;
    logic [3:0]  idx;
    logic [11:0] lvl;
    rx  = data[7:0];
    idx = data[11:8];
    lvl = data[23:12];
    if (kind == cpr_pkg::KIND_LEVEL) begin
      // drop updates to channels that do not exist
      if (idx < CHANNEL_COUNT) levels[idx] = LEVEL_BITS'(lvl);
    end else begin
      case (frame_pos)
        cpr_pkg::POS_IDLE: begin
          if (rx == cpr_pkg::START_BYTE) frame_pos = cpr_pkg::POS_HIGH;
        end
        cpr_pkg::POS_HIGH: begin
          pattern_hi = rx;
          frame_pos  = cpr_pkg::POS_LOW;
        end
        cpr_pkg::POS_LOW: begin
          pattern_lo = rx;
          frame_pos  = cpr_pkg::POS_IDLE;
          predict_reply();
        end
        default: frame_pos = cpr_pkg::POS_IDLE;
      endcase
    end
  endtask

  // Compare one reply transaction with the oldest expectation
  task automatic check_reply();
    reply_byte_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch("reply byte with nothing due", out_tdata, 0);
    end else begin
      want = expected_replies.pop_front();
      if (out_tdata !== want.tx_byte)
        report_mismatch("tx_byte", out_tdata, want.tx_byte);
      if (out_tlast !== want.last_byte)
        report_mismatch("last_byte", out_tlast, want.last_byte);
      if (out_tuser[0] !== want.pattern_match)
        report_mismatch("pattern_match", out_tuser[0], want.pattern_match);
      if (out_tuser[1] !== want.any_active)
        report_mismatch("any_active", out_tuser[1], want.any_active);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      threshold  = '0;
      frame_pos  = cpr_pkg::POS_IDLE;
      pattern_hi = '0;
      pattern_lo = '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) levels[i] = '0;
      expected_replies.delete();
    end else begin
      if (out_tvalid && out_tready) check_reply();
      if (in_tvalid && in_tready) absorb_input(in_tuser, in_tdata);
      if (cfg_wr_en) threshold = cfg_wr_data;
    end
    replies_due    <= expected_replies.size();
    mismatch_count <= errors;
  end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the channel pattern check responder: directed
// requests and level updates, then random phases under several thresholds
// with bursty input and a stalling reply side; checking is in the checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CHANNELS = 12;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en;
  logic [11:0] cfg_wr_data;
  int unsigned mismatch_count;
  int unsigned replies_due;

  // Stimulus bookkeeping used to aim patterns at the current map
  logic [11:0] level_shadow [CHANNELS];
  logic [11:0] thresh_shadow;
  logic        stall_enable;
  bit          sender_gaps;
  int          burst_left;
  int          items_sent;

  channel_pattern_check_responder_unit #(
    .CHANNEL_COUNT(CHANNELS),
    .LEVEL_BITS   (12)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  cpr_reply_checker #(
    .CHANNEL_COUNT(CHANNELS),
    .LEVEL_BITS   (12)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mismatch_count(mismatch_count),
    .replies_due   (replies_due)
  );

  // Clock: 20 time units period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Reply side: alternate ready and stall stretches, rarely long stalls
  always @(posedge clk) begin
    int pick;
    int hold_left;
    if (!stall_enable) begin
      out_tready <= 1'b1;
      hold_left = 0;
    end else if (hold_left != 0) begin
      hold_left--;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        out_tready <= 1'b1;
        hold_left = $urandom_range(0, 6);
      end else if (pick < 9) begin
        out_tready <= 1'b0;
        hold_left = $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        hold_left = $urandom_range(8, 24);
      end
    end
  end

  // Hand one transaction to the block, opening a new burst when due
  task automatic send_item(input logic kind, input logic [23:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_gaps ? $urandom_range(0, 5) : 0;
      if (sender_gaps && $urandom_range(0, 15) == 0) gap = $urandom_range(10, 20);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] rx);
    send_item(cpr_pkg::KIND_SERIAL, {12'($urandom), 4'($urandom), rx});
  endtask

  task automatic send_level(input logic [3:0] idx, input logic [11:0] lvl);
    send_item(cpr_pkg::KIND_LEVEL, {lvl, idx, 8'($urandom)});
    if (idx < CHANNELS) level_shadow[idx] = lvl;
  endtask

  task automatic send_request(input logic [15:0] pat);
    send_byte(cpr_pkg::START_BYTE);
    send_byte(pat[15:8]);
    send_byte(pat[7:0]);
  endtask

  // Hold off until every reply due has come out and the block has settled
  task automatic drain();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (replies_due != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [11:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    thresh_shadow = value;
  endtask

  function automatic logic [11:0] aimed_map();
    logic [11:0] m;
    m = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (level_shadow[i] > thresh_shadow) m[i] = 1'b1;
    end
    return m;
  endfunction

  // Mostly full-range levels, some right around the threshold
  function automatic logic [11:0] pick_level();
    int t;
    if ($urandom_range(0, 3) != 0) return 12'($urandom);
    t = int'(thresh_shadow) + $urandom_range(0, 2) - 1;
    if (t < 0) t = 0;
    if (t > 4095) t = 4095;
    return 12'(t);
  endfunction

  function automatic logic [3:0] pick_channel();
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(CHANNELS, 15));
    return 4'($urandom_range(0, CHANNELS - 1));
  endfunction

  // One random step: mostly whole requests and level updates, some noise
  task automatic random_step();
    int          pick;
    logic [15:0] pat;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      pat = 16'($urandom);
      if ($urandom_range(0, 2) == 0) pat = {4'($urandom), aimed_map()};
      send_byte(cpr_pkg::START_BYTE);
      send_byte(pat[15:8]);
      if ($urandom_range(0, 4) == 0) send_level(pick_channel(), pick_level());
      send_byte(pat[7:0]);
    end else if (pick < 15) begin
      send_level(pick_channel(), pick_level());
    end else if (pick < 17) begin
      send_byte(8'($urandom));
    end else if (pick == 17) begin
      send_byte(cpr_pkg::START_BYTE);
    end else begin
      send_byte(cpr_pkg::START_BYTE);
      send_byte(8'($urandom));
    end
  endtask

  // Abort a run that hangs
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [11:0] thresh;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = cpr_pkg::KIND_SERIAL;
    out_tready   = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    stall_enable = 1'b0;
    sender_gaps  = 1'b0;
    burst_left   = 0;
    items_sent   = 0;
    thresh_shadow = '0;
    for (int i = 0; i < CHANNELS; i++) level_shadow[i] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: wrong start bytes, empty map, ignored channels, masking,
    // start byte as pattern data, level update inside a request
    send_byte(8'h00);
    send_byte(8'hFF);
    send_request(16'h0000);
    send_level(4'd0, 12'hFFF);
    send_level(4'd11, 12'h001);
    send_level(4'd12, 12'hFFF);
    send_level(4'd15, 12'hFFF);
    send_request(16'hF801);
    send_request({cpr_pkg::START_BYTE, cpr_pkg::START_BYTE});
    send_byte(cpr_pkg::START_BYTE);
    send_byte(8'h08);
    send_level(4'd5, 12'hABC);
    send_byte(8'h21);
    send_level(4'd0, 12'h000);
    send_request(16'h0820);

    // Random phases across thresholds, including both extremes
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       thresh = 12'hFFF;
        1:       thresh = 12'h000;
        2:       thresh = 12'hFFE;
        default: thresh = 12'($urandom);
      endcase
      set_threshold(thresh);
      stall_enable <= (phase % 3 != 0);
      sender_gaps = (phase % 2 == 1) || (phase == 4);
      items_sent = 0;
      while (items_sent < 67) random_step();
    end

    drain();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cpr_pkg.sv
rtl/core/cpr_front.sv
rtl/core/cpr_queue.sv
rtl/core/cpr_back.sv
rtl/core/channel_pattern_check_responder_unit.sv
dv/cpr_reply_checker.sv
dv/testbench.sv
